[rtl/gbs_pkg.sv]
// Shared types and constants for the greedy box suppression unit.
package gbs_pkg;

   localparam int COORD_W  = 16;                // Q12.4 coordinate and size width
   localparam int EDGE_W   = COORD_W + 2;       // exact right/bottom edge, signed
   localparam int AREA_W   = 2 * COORD_W;       // width * height
   localparam int UNION_W  = AREA_W + 1;        // area_a + area_b - inter
   localparam int THR_W    = 8;                 // threshold in 1/256 units
   localparam int SHIFT_W  = AREA_W + THR_W;    // inter * 256
   localparam int PROD_W   = UNION_W + THR_W;   // threshold * union
   localparam int TOTAL_W  = 7;                 // reported kept count
   localparam int BOX_W    = 4 * COORD_W;       // one stored box

   localparam int              MAX_KEPT_DEF = 64;
   localparam logic [THR_W-1:0] THR_RESET   = 8'd128;  // IoU 0.5

   // Stored box, left edge in the low bits
   typedef struct packed {
      logic        [COORD_W-1:0] box_height;
      logic        [COORD_W-1:0] box_width;
      logic signed [COORD_W-1:0] box_top;
      logic signed [COORD_W-1:0] box_left;
   } kept_box_type;

   typedef struct packed {
      logic                      frame_start;
      logic signed [COORD_W-1:0] box_left;
      logic signed [COORD_W-1:0] box_top;
      logic        [COORD_W-1:0] box_width;
      logic        [COORD_W-1:0] box_height;
   } req_payload_type;

   typedef struct packed {
      logic               keep;
      logic [TOTAL_W-1:0] kept_total;
      logic               store_full;
   } rsp_payload_type;

   // Status of the overlap compare pipeline
   typedef struct packed {
      logic busy;
      logic hit_valid;
      logic hit;
   } cmp_status_type;

endpackage

[rtl/gbs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module gbs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/gbs_iou_unit.sv]
// Pipelined overlap test of the current box against one stored box per cycle.
module gbs_iou_unit
   import gbs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  kept_box_type       kept_box,
   input  kept_box_type       cur_box,
   input  logic [AREA_W-1:0]  cur_area,
   input  logic [THR_W-1:0]   threshold,
   output cmp_status_type     status
);

   // Positive overlap of two intervals, zero when they do not overlap
   function automatic logic [COORD_W-1:0] overlap(
      input logic signed [EDGE_W-1:0] a0,
      input logic signed [EDGE_W-1:0] a1,
      input logic signed [EDGE_W-1:0] b0,
      input logic signed [EDGE_W-1:0] b1
   );
      logic signed [EDGE_W-1:0] hi;
      logic signed [EDGE_W-1:0] lo;
      logic signed [EDGE_W:0]   diff;
      hi   = (a1 < b1) ? a1 : b1;
      lo   = (a0 > b0) ? a0 : b0;
      diff = (EDGE_W+1)'(hi) - (EDGE_W+1)'(lo);
      return (diff > 0) ? COORD_W'(diff) : '0;
   endfunction

   logic signed [EDGE_W-1:0] a_x0, a_x1, a_y0, a_y1;
   logic signed [EDGE_W-1:0] b_x0, b_x1, b_y0, b_y1;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff, hit_valid_ff;
   logic [COORD_W-1:0]   iw_ff, ih_ff, bw_ff, bh_ff;
   logic [COORD_W-1:0]   iw_in, ih_in;
   logic [AREA_W-1:0]    inter_ff, area_b_ff;
   logic [UNION_W-1:0]   union_ff, union_in;
   logic [SHIFT_W-1:0]   inter_sh_ff, inter_sh4_ff;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic                 hit_ff, hit_in;

   // Stage 1: edges and clamped intersection extents
   always_comb begin
      a_x0  = EDGE_W'(cur_box.box_left);
      a_y0  = EDGE_W'(cur_box.box_top);
      a_x1  = a_x0 + $signed(EDGE_W'(cur_box.box_width));
      a_y1  = a_y0 + $signed(EDGE_W'(cur_box.box_height));
      b_x0  = EDGE_W'(kept_box.box_left);
      b_y0  = EDGE_W'(kept_box.box_top);
      b_x1  = b_x0 + $signed(EDGE_W'(kept_box.box_width));
      b_y1  = b_y0 + $signed(EDGE_W'(kept_box.box_height));
      iw_in = overlap(a_x0, a_x1, b_x0, b_x1);
      ih_in = overlap(a_y0, a_y1, b_y0, b_y1);
   end

   // Stages 3 to 5: union, threshold product, compare
   assign union_in = UNION_W'(cur_area) + UNION_W'(area_b_ff) - UNION_W'(inter_ff);
   assign prod_in  = PROD_W'(threshold) * PROD_W'(union_ff);
   assign hit_in   = PROD_W'(inter_sh4_ff) > prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         hit_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         hit_valid_ff <= v4_ff;
      end
      iw_ff        <= iw_in;
      ih_ff        <= ih_in;
      bw_ff        <= kept_box.box_width;
      bh_ff        <= kept_box.box_height;
      inter_ff     <= iw_ff * ih_ff;
      area_b_ff    <= bw_ff * bh_ff;
      union_ff     <= union_in;
      inter_sh_ff  <= {inter_ff, {THR_W{1'b0}}};
      prod_ff      <= prod_in;
      inter_sh4_ff <= inter_sh_ff;
      hit_ff       <= hit_in;
   end

   assign status.busy      = v1_ff | v2_ff | v3_ff | v4_ff | hit_valid_ff;
   assign status.hit_valid = hit_valid_ff;
   assign status.hit       = hit_ff;

endmodule

[rtl/greedy_box_suppression_unit.sv]
// Greedy box suppression: top level with kept-box store and scan sequencer.
// A result follows the scan of the N stored boxes and the drain of the compare pipe, N = stored boxes.
// A new box is taken only once the previous result is formed; the store reads one kept box per cycle.
// A new box is accepted while the previous result still waits on the output.
// Reset clears the kept count and sets the threshold to 128; store contents
// are not cleared, only entries below the kept count are ever read.
module greedy_box_suppression_unit
   import gbs_pkg::*;
#(
   parameter int MAX_KEPT = MAX_KEPT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_payload_type   req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_payload_type   rsp_payload,
   input  logic              csr_wr_en,
   input  logic [THR_W-1:0]  csr_wr_data
);

   localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CNT_W  = $clog2(MAX_KEPT + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               kill_ff, kill_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [THR_W-1:0]   thr_ff, thr_in;
   kept_box_type       box_ff, box_in;
   logic [AREA_W-1:0]  area_ff, area_in;
   rsp_payload_type    rsp_ff, rsp_in;

   logic               accept;
   logic               done;
   logic               keep;
   logic               can_store;
   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [BOX_W-1:0]   ram_rd_data;
   kept_box_type       kept_box;
   cmp_status_type     cmp;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign keep      = !kill_ff;
   assign can_store = count_ff < CNT_W'(MAX_KEPT);
   assign done      = (state_ff == ST_DRAIN) && !rd_vld_ff && !cmp.busy
                      && (!rsp_valid_ff || rsp_ready);
   assign ram_wr_en = done && keep && can_store;
   assign ram_rd_en = (state_ff == ST_SCAN) && (rd_ptr_ff != count_ff);
   assign kept_box  = kept_box_type'(ram_rd_data);

   // Sequencer: accept, scan the store, drain the compare pipe, report
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_vld_in    = ram_rd_en;
      kill_in      = kill_ff | (cmp.hit_valid & cmp.hit);
      rsp_valid_in = rsp_valid_ff & !rsp_ready;
      thr_in       = csr_wr_en ? csr_wr_data : thr_ff;
      box_in       = box_ff;
      area_in      = area_ff;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               box_in.box_left   = req_payload.box_left;
               box_in.box_top    = req_payload.box_top;
               box_in.box_width  = req_payload.box_width;
               box_in.box_height = req_payload.box_height;
               area_in   = req_payload.box_width * req_payload.box_height;
               count_in  = req_payload.frame_start ? '0 : count_ff;
               rd_ptr_in = '0;
               kill_in   = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (ram_rd_en) begin
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (done) begin
               count_in          = count_ff + CNT_W'(ram_wr_en);
               rsp_in.keep       = keep;
               rsp_in.kept_total = TOTAL_W'(count_in);
               rsp_in.store_full = keep && !can_store;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_ptr_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         kill_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= THR_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_ptr_ff    <= rd_ptr_in;
         rd_vld_ff    <= rd_vld_in;
         kill_ff      <= kill_in;
         rsp_valid_ff <= rsp_valid_in;
         thr_ff       <= thr_in;
      end
      box_ff  <= box_in;
      area_ff <= area_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Kept-box store
   gbs_ram #(
      .WIDTH (BOX_W),
      .DEPTH (MAX_KEPT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (BOX_W'(box_ff)),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // Overlap compare pipeline
   gbs_iou_unit u_iou (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_vld_ff),
      .kept_box  (kept_box),
      .cur_box   (box_ff),
      .cur_area  (area_ff),
      .threshold (thr_ff),
      .status    (cmp)
   );

   // Kept count never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_KEPT))
      else $error("kept count above store depth");

   // Store is never written while a scan read is issued
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("store write during scan read");

   // Compare results only arrive while an item is in work
   a_hit_in_work: assert property (@(posedge clock) disable iff (reset)
      cmp.hit_valid |-> (state_ff != ST_IDLE))
      else $error("compare result with no item in work");

   // A new beat finds the compare pipe empty
   a_accept_idle_pipe: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!cmp.busy && !rd_vld_ff))
      else $error("beat accepted with compare pipe busy");

   // A stored box raises the count by one in the following cycle
   a_write_counts: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("store write without count advance");

endmodule
